/* design/dd_pkg.sv */
// Shared types, constants and the month table for the date difference pipeline.
package dd_pkg;

  localparam int DIV_N    = 17;
  localparam int PROD_W   = 35;
  localparam int MAGIC_W  = 18;
  localparam logic [MAGIC_W-1:0] M100 = 18'd167773;
  localparam logic [MAGIC_W-1:0] M400 = 18'd167773;
  localparam int S100     = 24;
  localparam int S400     = 26;
  localparam int TOD_W    = 17;
  localparam int TODD_W   = 18;
  localparam int TOTAL_W  = 38;
  localparam int WDAYS_W  = 22;
  localparam int REM_W    = 18;
  localparam int MONTH_W  = 4;
  localparam int DBM_W    = 9;
  localparam logic [MONTH_W-1:0] MARCH = 4'd3;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dd_time_t;

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] mo);
    logic [DBM_W-1:0] r;
    case (mo)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

/* design/dd_if.sv */
// Valid/ready channel interfaces for the date pair words and the difference words.
interface dd_in_if #(parameter int YEAR_BITS = 12);
  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] left_year;
  logic [3:0]           left_month;
  logic [4:0]           left_day;
  logic [4:0]           left_hour;
  logic [5:0]           left_minute;
  logic [5:0]           left_second;
  logic [YEAR_BITS-1:0] right_year;
  logic [3:0]           right_month;
  logic [4:0]           right_day;
  logic [4:0]           right_hour;
  logic [5:0]           right_minute;
  logic [5:0]           right_second;

  modport source (output valid, left_year, left_month, left_day, left_hour, left_minute,
                  left_second, right_year, right_month, right_day, right_hour,
                  right_minute, right_second, input ready);
  modport sink (input valid, left_year, left_month, left_day, left_hour, left_minute,
                left_second, right_year, right_month, right_day, right_hour,
                right_minute, right_second, output ready);
endinterface

interface dd_out_if;
  logic               valid;
  logic               ready;
  logic signed [37:0] total_seconds;
  logic signed [21:0] whole_days;
  logic signed [17:0] remainder_seconds;

  modport source (output valid, total_seconds, whole_days, remainder_seconds, input ready);
  modport sink (input valid, total_seconds, whole_days, remainder_seconds, output ready);
endinterface

/* design/dd_day_count.sv */
// Three-stage pipeline turning one date-time into a day count and a second-of-day offset.
module dd_day_count #(
  parameter int YEAR_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [YEAR_BITS-1:0]     year,
  input  dd_pkg::dd_time_t         tm,
  output logic                     out_valid,
  output logic [YEAR_BITS+8:0]     days,
  output logic [dd_pkg::TOD_W-1:0] tod
);

  localparam int DAY_W  = YEAR_BITS + 9;
  localparam int N      = dd_pkg::DIV_N;
  localparam int PW     = dd_pkg::PROD_W;
  localparam int TW     = dd_pkg::TOD_W;
  localparam int Q100_W = PW - dd_pkg::S100;
  localparam int Q400_W = PW - dd_pkg::S400;

  // stage 1: reciprocal products for the century corrections
  logic [N-1:0]         yx;
  logic [PW-1:0]        p100_nxt, p400_nxt;
  logic [PW-1:0]        p100_r, p400_r;
  logic [YEAR_BITS-1:0] y1_r;
  dd_pkg::dd_time_t     tm1_r;
  logic                 v1_r;

  assign yx       = {{(N-YEAR_BITS){1'b0}}, year};
  assign p100_nxt = PW'(yx + N'(99)) * PW'(dd_pkg::M100);
  assign p400_nxt = PW'(yx + N'(399)) * PW'(dd_pkg::M400);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p100_r <= p100_nxt;
      p400_r <= p400_nxt;
      y1_r   <= year;
      tm1_r  <= tm;
    end
  end

  // stage 2: days before the year and leap flag
  logic [N-1:0]      y1x;
  logic [N-1:0]      q4;
  logic [Q100_W-1:0] q100;
  logic [Q400_W-1:0] q400;
  logic [DAY_W-1:0]  dy_nxt, dy2_r;
  logic              leap_nxt, leap2_r;
  dd_pkg::dd_time_t  tm2_r;
  logic              v2_r;

  assign y1x  = {{(N-YEAR_BITS){1'b0}}, y1_r};
  assign q4   = (y1x + N'(3)) >> 2;
  assign q100 = p100_r[PW-1:dd_pkg::S100];
  assign q400 = p400_r[PW-1:dd_pkg::S400];
  assign dy_nxt = DAY_W'(y1_r) * DAY_W'(365) + DAY_W'(q4) - DAY_W'(q100) + DAY_W'(q400);
  assign leap_nxt = ((y1x[1:0] == 2'b00) && ((N'(q100) * N'(100)) != y1x))
                  || ((N'(q400) * N'(400)) == y1x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dy2_r   <= dy_nxt;
      leap2_r <= leap_nxt;
      tm2_r   <= tm1_r;
    end
  end

  // stage 3: month, day and time of day
  logic [dd_pkg::DBM_W-1:0] dbm;
  logic                     leap_add;
  logic [DAY_W-1:0]         days_nxt, days_r;
  logic [TW-1:0]            tod_nxt, tod_r;
  logic                     v3_r;

  assign dbm      = dd_pkg::days_before_month(tm2_r.month);
  assign leap_add = leap2_r && (tm2_r.month >= dd_pkg::MARCH);
  assign days_nxt = dy2_r + DAY_W'(dbm) + DAY_W'(tm2_r.day) + DAY_W'(leap_add);
  assign tod_nxt  = TW'(tm2_r.hour) * TW'(3600) + TW'(tm2_r.minute) * TW'(60)
                  + TW'(tm2_r.second);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days_r <= days_nxt;
      tod_r  <= tod_nxt;
    end
  end

  assign out_valid = v3_r;
  assign days      = days_r;
  assign tod       = tod_r;

endmodule

/* design/dd_split.sv */
// Three-stage pipeline forming the signed difference and its day/second split.
module dd_split #(
  parameter int YEAR_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [YEAR_BITS+8:0]             days_l,
  input  logic [YEAR_BITS+8:0]             days_r,
  input  logic [dd_pkg::TOD_W-1:0]         tod_l,
  input  logic [dd_pkg::TOD_W-1:0]         tod_r,
  output logic                             out_valid,
  output logic signed [dd_pkg::TOTAL_W-1:0] total_seconds,
  output logic signed [dd_pkg::WDAYS_W-1:0] whole_days,
  output logic signed [dd_pkg::REM_W-1:0]   remainder_seconds
);

  localparam int DAY_W = YEAR_BITS + 9;
  localparam int DD_W  = DAY_W + 1;
  localparam int TD_W  = dd_pkg::TODD_W;
  localparam int TOT_W = DD_W + TD_W;
  localparam logic signed [TD_W-1:0] SPD = 18'sd86400;
  localparam logic signed [TD_W-1:0] NSPD = -18'sd86400;

  // stage 4: raw differences
  logic signed [DD_W-1:0] dd4_r;
  logic signed [TD_W-1:0] td4_r;
  logic                   v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd4_r <= signed'(DD_W'(days_l) - DD_W'(days_r));
      td4_r <= signed'(TD_W'(tod_l) - TD_W'(tod_r));
    end
  end

  // stage 5: exact total in seconds
  logic signed [TOT_W-1:0] tot_nxt, tot5_r;
  logic signed [DD_W-1:0]  dd5_r;
  logic signed [TD_W-1:0]  td5_r;
  logic                    v5_r;

  assign tot_nxt = TOT_W'(dd4_r) * TOT_W'(SPD) + TOT_W'(td4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot5_r <= tot_nxt;
      dd5_r  <= dd4_r;
      td5_r  <= td4_r;
    end
  end

  // stage 6: fold the time-of-day spill into the day count, truncating toward zero
  logic signed [2:0]      adj;
  logic signed [TD_W:0]   rem_w;
  logic signed [TD_W:0]   tdx;
  logic signed [DD_W:0]   q_w;
  logic signed [63:0]     tot_ext, q_ext;
  logic signed [dd_pkg::TOTAL_W-1:0] tot6_r;
  logic signed [dd_pkg::WDAYS_W-1:0] q6_r;
  logic signed [dd_pkg::REM_W-1:0]   rem6_r;
  logic                   v6_r;

  assign tdx = td5_r;

  always_comb begin
    adj = 3'sd0;
    if (!tot5_r[TOT_W-1]) begin
      if (td5_r >= SPD) begin
        adj = 3'sd1;
      end else if (td5_r >= 0) begin
        adj = 3'sd0;
      end else if (td5_r >= NSPD) begin
        adj = -3'sd1;
      end else begin
        adj = -3'sd2;
      end
    end else begin
      if (td5_r <= NSPD) begin
        adj = -3'sd1;
      end else if (td5_r <= 0) begin
        adj = 3'sd0;
      end else if (td5_r <= SPD) begin
        adj = 3'sd1;
      end else begin
        adj = 3'sd2;
      end
    end
  end

  assign rem_w   = tdx - (TD_W+1)'(adj) * (TD_W+1)'(SPD);
  assign q_w     = (DD_W+1)'(dd5_r) + (DD_W+1)'(adj);
  assign tot_ext = tot5_r;
  assign q_ext   = q_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot6_r <= tot_ext[dd_pkg::TOTAL_W-1:0];
      q6_r   <= q_ext[dd_pkg::WDAYS_W-1:0];
      rem6_r <= rem_w[dd_pkg::REM_W-1:0];
    end
  end

  assign out_valid         = v6_r;
  assign total_seconds     = tot6_r;
  assign whole_days        = q6_r;
  assign remainder_seconds = rem6_r;

endmodule

/* design/date_difference_days.sv */
// Top level of the Gregorian date-time difference pipeline.
// Usage:
//   in_ch carries one word per pair of date-times (left and right: year, month, day,
//   hour, minute, second). out_ch returns one word per input word: left minus right as
//   exact signed seconds, plus whole days and leftover seconds, both truncated toward
//   zero.
//   A word accepted on in_ch passes through six pipeline stages (three of day counting
//   per side, three of differencing and split) to out_ch. A new word is accepted every
//   cycle while the receiver does not stall; throughput is one word per cycle.
//   When the receiver stalls, the whole pipeline holds and in_ch.ready drops as soon as
//   the output register holds an untaken word; nothing is lost or repeated.
//   Synchronous reset clears all valid bits; the pipeline is empty after reset.
//   YEAR_BITS sets the year field width; results too wide for an output wrap.
module date_difference_days #(
  parameter int YEAR_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  dd_in_if.sink        in_ch,
  dd_out_if.source     out_ch
);

  localparam int DAY_W = YEAR_BITS + 9;

  logic                     en;
  logic                     vl, vr;
  logic [DAY_W-1:0]         days_l, days_r;
  logic [dd_pkg::TOD_W-1:0] tod_l, tod_r;
  dd_pkg::dd_time_t         tm_l, tm_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign tm_l = '{month: in_ch.left_month, day: in_ch.left_day, hour: in_ch.left_hour,
                  minute: in_ch.left_minute, second: in_ch.left_second};
  assign tm_r = '{month: in_ch.right_month, day: in_ch.right_day, hour: in_ch.right_hour,
                  minute: in_ch.right_minute, second: in_ch.right_second};

  dd_day_count #(.YEAR_BITS(YEAR_BITS)) u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .year      (in_ch.left_year),
    .tm        (tm_l),
    .out_valid (vl),
    .days      (days_l),
    .tod       (tod_l)
  );

  dd_day_count #(.YEAR_BITS(YEAR_BITS)) u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .year      (in_ch.right_year),
    .tm        (tm_r),
    .out_valid (vr),
    .days      (days_r),
    .tod       (tod_r)
  );

  dd_split #(.YEAR_BITS(YEAR_BITS)) u_split (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (vl && vr),
    .days_l            (days_l),
    .days_r            (days_r),
    .tod_l             (tod_l),
    .tod_r             (tod_r),
    .out_valid         (out_ch.valid),
    .total_seconds     (out_ch.total_seconds),
    .whole_days        (out_ch.whole_days),
    .remainder_seconds (out_ch.remainder_seconds)
  );

endmodule

/* verif/dd_diff_checker.sv */
// Checker for the date difference block: predicts each difference word and compares.
`timescale 1ns / 100ps

module dd_diff_checker #(
  parameter int YEAR_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  dd_in_if     in_ch,
  dd_out_if    out_ch,
  output int   mismatches,
  output int   owed
);

  typedef struct packed {
    logic signed [dd_pkg::TOTAL_W-1:0] total;
    logic signed [dd_pkg::WDAYS_W-1:0] days;
    logic signed [dd_pkg::REM_W-1:0]   rem;
  } diff_word_t;

  // days before each month of a common year, indexed by the raw month field
  int month_start [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
                           334, 334, 334};

  diff_word_t owed_diffs [$];

  function automatic longint stamp_seconds(logic [YEAR_BITS-1:0] yr, dd_pkg::dd_time_t t);
    longint y;
    longint days;
    bit     leap;
    y    = longint'(yr);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
           + month_start[t.month] + longint'(t.day);
    if (t.month >= dd_pkg::MARCH && leap) days = days + 1;
    return days * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
           + longint'(t.second);
  endfunction

  function automatic diff_word_t predict_diff(logic [YEAR_BITS-1:0] ly, dd_pkg::dd_time_t lt,
                                              logic [YEAR_BITS-1:0] ry, dd_pkg::dd_time_t rt);
    diff_word_t w;
    longint     d;
    longint     q;
    longint     r;
    d = stamp_seconds(ly, lt) - stamp_seconds(ry, rt);
    q = d / 86400;
    r = d % 86400;
    w.total = d[dd_pkg::TOTAL_W-1:0];
    w.days  = q[dd_pkg::WDAYS_W-1:0];
    w.rem   = r[dd_pkg::REM_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    diff_word_t       got;
    diff_word_t       want;
    dd_pkg::dd_time_t lt;
    dd_pkg::dd_time_t rt;
    if (!rst_n) begin
      owed_diffs.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lt = '{in_ch.left_month, in_ch.left_day, in_ch.left_hour, in_ch.left_minute,
               in_ch.left_second};
        rt = '{in_ch.right_month, in_ch.right_day, in_ch.right_hour, in_ch.right_minute,
               in_ch.right_second};
        owed_diffs.push_back(predict_diff(in_ch.left_year, lt, in_ch.right_year, rt));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.total_seconds, out_ch.whole_days, out_ch.remainder_seconds};
        if (owed_diffs.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected word total=%0d days=%0d rem=%0d", $realtime,
                     got.total, got.days, got.rem);
        end else begin
          want = owed_diffs.pop_front();
          if (got.total !== want.total || got.days !== want.days || got.rem !== want.rem)
          begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"%0t: word differs: exp total=%0d days=%0d rem=%0d, ",
                        "got total=%0d days=%0d rem=%0d"},
                       $realtime, want.total, want.days, want.rem,
                       got.total, got.days, got.rem);
          end
        end
      end
    end
    owed = owed_diffs.size();
  end

endmodule

/* verif/tb_date_difference_days.sv */
// Testbench top for date_difference_days: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 100ps

module tb_date_difference_days;

  localparam int YB         = 12;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_LEN  = 150;

  logic clk = 1'b0;
  logic rst_n;

  int  send_idle = 0;
  int  recv_idle = 0;
  bit  hold_out  = 1'b0;
  int  quiet_cycles = 0;
  int  mismatches;
  int  owed;

  dd_in_if #(.YEAR_BITS(YB)) in_if ();
  dd_out_if                  out_if ();

  date_difference_days #(.YEAR_BITS(YB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  dd_diff_checker #(.YEAR_BITS(YB)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .mismatches (mismatches),
    .owed       (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_out = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic dd_pkg::dd_time_t stamp(int mo, int d, int h, int mi, int s);
    dd_pkg::dd_time_t t;
    t.month  = mo[3:0];
    t.day    = d[4:0];
    t.hour   = h[4:0];
    t.minute = mi[5:0];
    t.second = s[5:0];
    return t;
  endfunction

  function automatic dd_pkg::dd_time_t legal_time();
    return stamp($urandom_range(12, 1), $urandom_range(31, 1), $urandom_range(23),
                 $urandom_range(59), $urandom_range(59));
  endfunction

  function automatic dd_pkg::dd_time_t wild_time();
    return stamp($urandom_range(15), $urandom_range(31), $urandom_range(31),
                 $urandom_range(63), $urandom_range(63));
  endfunction

  function automatic logic [YB-1:0] legal_year();
    if ($urandom_range(3) == 0)
      return YB'($urandom_range(40, 1) * 100);
    return YB'($urandom_range(4095, 1));
  endfunction

  // one word offered from a falling edge, held until taken; returns at a falling edge
  task automatic offer(input logic [YB-1:0] ly, input dd_pkg::dd_time_t lt,
                       input logic [YB-1:0] ry, input dd_pkg::dd_time_t rt);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.left_year    <= ly;
    in_if.left_month   <= lt.month;
    in_if.left_day     <= lt.day;
    in_if.left_hour    <= lt.hour;
    in_if.left_minute  <= lt.minute;
    in_if.left_second  <= lt.second;
    in_if.right_year   <= ry;
    in_if.right_month  <= rt.month;
    in_if.right_day    <= rt.day;
    in_if.right_hour   <= rt.hour;
    in_if.right_minute <= rt.minute;
    in_if.right_second <= rt.second;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  task automatic random_word();
    logic [YB-1:0]    ly;
    logic [YB-1:0]    ry;
    dd_pkg::dd_time_t lt;
    dd_pkg::dd_time_t rt;
    int               pick;
    int               shift;
    pick = $urandom_range(99);
    if (pick < 15) begin
      ly = YB'($urandom);
      ry = YB'($urandom);
      lt = wild_time();
      rt = wild_time();
    end else if (pick < 45) begin
      // near pairs: differences around zero and whole-day boundaries
      ly = legal_year();
      lt = legal_time();
      ry = ly;
      rt = lt;
      shift = $urandom_range(2);
      rt.day    = 5'((int'(lt.day) + shift > 31) ? int'(lt.day) - shift
                                                 : int'(lt.day) + shift);
      if ($urandom_range(1))
        rt.day = 5'(int'(lt.day) - ((int'(lt.day) > shift) ? shift : 0));
      rt.hour   = $urandom_range(1) ? lt.hour : 5'($urandom_range(23));
      rt.minute = $urandom_range(1) ? lt.minute : 6'($urandom_range(59));
      rt.second = 6'($urandom_range(59));
    end else begin
      ly = legal_year();
      lt = legal_time();
      rt = legal_time();
      if ($urandom_range(1)) begin
        shift = int'(ly) + int'($urandom_range(6)) - 3;
        ry = YB'((shift < 1) ? 1 : (shift > 4095) ? 4095 : shift);
      end else begin
        ry = legal_year();
      end
    end
    if ($urandom_range(1)) offer(ly, lt, ry, rt);
    else offer(ry, rt, ly, lt);
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input bit with_hold);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (with_hold && i == 10) hold_out = 1'b1;
      random_word();
    end
    drain();
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.left_year    = '0;
    in_if.left_month   = '0;
    in_if.left_day     = '0;
    in_if.left_hour    = '0;
    in_if.left_minute  = '0;
    in_if.left_second  = '0;
    in_if.right_year   = '0;
    in_if.right_month  = '0;
    in_if.right_day    = '0;
    in_if.right_hour   = '0;
    in_if.right_minute = '0;
    in_if.right_second = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed words: extremes, sign and day boundaries, leap rules, odd field values
    offer(0, stamp(0, 0, 0, 0, 0), 0, stamp(0, 0, 0, 0, 0));
    offer(4095, stamp(15, 31, 31, 63, 63), 0, stamp(0, 0, 0, 0, 0));
    offer(0, stamp(0, 0, 0, 0, 0), 4095, stamp(15, 31, 31, 63, 63));
    offer(2024, stamp(6, 15, 12, 30, 30), 2024, stamp(6, 15, 12, 30, 30));
    offer(2024, stamp(1, 1, 0, 0, 0), 2024, stamp(1, 1, 0, 0, 1));
    offer(2024, stamp(1, 1, 0, 0, 0), 2024, stamp(1, 2, 0, 0, 0));
    offer(2024, stamp(1, 1, 0, 0, 0), 2024, stamp(1, 2, 0, 0, 1));
    offer(2024, stamp(1, 1, 23, 59, 59), 2024, stamp(1, 1, 0, 0, 0));
    offer(2000, stamp(3, 1, 0, 0, 0), 2000, stamp(2, 28, 0, 0, 0));
    offer(1900, stamp(3, 1, 0, 0, 0), 1900, stamp(2, 28, 0, 0, 0));
    offer(2004, stamp(3, 1, 0, 0, 0), 2004, stamp(2, 28, 0, 0, 0));
    offer(2001, stamp(3, 1, 0, 0, 0), 2001, stamp(2, 28, 0, 0, 0));
    offer(0, stamp(3, 1, 0, 0, 0), 0, stamp(2, 28, 0, 0, 0));
    offer(1, stamp(1, 1, 0, 0, 0), 0, stamp(1, 1, 0, 0, 0));
    offer(2023, stamp(0, 10, 0, 0, 0), 2023, stamp(1, 10, 0, 0, 0));
    offer(2024, stamp(0, 0, 0, 0, 0), 2023, stamp(12, 31, 0, 0, 0));
    offer(2023, stamp(13, 5, 0, 0, 0), 2023, stamp(12, 5, 0, 0, 0));
    offer(2024, stamp(14, 5, 0, 0, 0), 2024, stamp(12, 5, 0, 0, 0));
    offer(2024, stamp(15, 5, 1, 2, 3), 2024, stamp(12, 6, 0, 0, 0));
    offer(2023, stamp(2, 31, 31, 63, 63), 2023, stamp(3, 3, 0, 0, 0));
    offer(4095, stamp(12, 31, 23, 59, 59), 1, stamp(1, 1, 0, 0, 0));
    offer(1, stamp(1, 1, 0, 0, 0), 4095, stamp(12, 31, 23, 59, 59));
    drain();

    run_phase(31, 48, 1'b0);
    run_phase(48, 31, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (20) @(negedge clk);
    if (mismatches == 0 && owed == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
design/dd_pkg.sv
design/dd_if.sv
design/dd_day_count.sv
design/dd_split.sv
design/date_difference_days.sv
verif/dd_diff_checker.sv
verif/tb_date_difference_days.sv
